FILE: src/mbss_pkg.sv
`timescale 1ns / 1ps

package mbss_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int BYTE_W      = 8;
  localparam int ADDR_W      = 32;
  localparam int LEN_W       = 6;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int PAT_W       = MAX_PATTERN * BYTE_W;

  typedef enum logic [2:0] {
    REG_PATTERN_WORD_0 = 3'd0,
    REG_PATTERN_WORD_1 = 3'd1,
    REG_PATTERN_WORD_2 = 3'd2,
    REG_PATTERN_WORD_3 = 3'd3,
    REG_CARE_MASK      = 3'd4,
    REG_PATTERN_LENGTH = 3'd5,
    REG_ADDRESS_OFFSET = 3'd6
  } reg_idx_t;

  // pattern and care bits right-aligned to the newest window slot
  typedef struct packed {
    logic [PAT_W-1:0]       pattern;
    logic [MAX_PATTERN-1:0] care;
    logic [LEN_W-1:0]       length;
    logic [ADDR_W-1:0]      offset_adj;
  } scan_cfg_t;

endpackage

FILE: src/mbss_cfg.sv
`timescale 1ns / 1ps

module mbss_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mbss_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [mbss_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [mbss_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output mbss_pkg::scan_cfg_t                  cfg
);

  logic [mbss_pkg::CFG_DATA_W-1:0]  pattern_word_r [4];
  logic [mbss_pkg::MAX_PATTERN-1:0] care_mask_r;
  logic [mbss_pkg::LEN_W-1:0]       pattern_length_r;
  logic [mbss_pkg::ADDR_W-1:0]      address_offset_r;
  mbss_pkg::scan_cfg_t              cfg_r;
  mbss_pkg::scan_cfg_t              cfg_nxt;

  mbss_pkg::reg_idx_t               reg_idx;
  logic                             wr_en;
  logic [mbss_pkg::LEN_W-1:0]       len_eff;
  logic [mbss_pkg::LEN_W-1:0]       shift_bytes;
  logic [mbss_pkg::PAT_W-1:0]       pattern_all;

  assign reg_idx = mbss_pkg::reg_idx_t'(paddr[5:3]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        pattern_word_r[i] <= '0;
      end
      care_mask_r      <= '0;
      pattern_length_r <= mbss_pkg::LEN_W'(1);
      address_offset_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        mbss_pkg::REG_PATTERN_WORD_0: pattern_word_r[0] <= pwdata;
        mbss_pkg::REG_PATTERN_WORD_1: pattern_word_r[1] <= pwdata;
        mbss_pkg::REG_PATTERN_WORD_2: pattern_word_r[2] <= pwdata;
        mbss_pkg::REG_PATTERN_WORD_3: pattern_word_r[3] <= pwdata;
        mbss_pkg::REG_CARE_MASK:      care_mask_r      <= pwdata[mbss_pkg::MAX_PATTERN-1:0];
        mbss_pkg::REG_PATTERN_LENGTH: pattern_length_r <= pwdata[mbss_pkg::LEN_W-1:0];
        mbss_pkg::REG_ADDRESS_OFFSET: address_offset_r <= pwdata[mbss_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mbss_pkg::REG_PATTERN_WORD_0: prdata = pattern_word_r[0];
      mbss_pkg::REG_PATTERN_WORD_1: prdata = pattern_word_r[1];
      mbss_pkg::REG_PATTERN_WORD_2: prdata = pattern_word_r[2];
      mbss_pkg::REG_PATTERN_WORD_3: prdata = pattern_word_r[3];
      mbss_pkg::REG_CARE_MASK:      prdata = mbss_pkg::CFG_DATA_W'(care_mask_r);
      mbss_pkg::REG_PATTERN_LENGTH: prdata = mbss_pkg::CFG_DATA_W'(pattern_length_r);
      mbss_pkg::REG_ADDRESS_OFFSET: prdata = mbss_pkg::CFG_DATA_W'(address_offset_r);
      default:                      prdata = '0;
    endcase
  end

  // zero length acts as one, oversize clamps to the window depth
  always_comb begin
    if (pattern_length_r == '0) begin
      len_eff = mbss_pkg::LEN_W'(1);
    end else if (pattern_length_r > mbss_pkg::LEN_W'(mbss_pkg::MAX_PATTERN)) begin
      len_eff = mbss_pkg::LEN_W'(mbss_pkg::MAX_PATTERN);
    end else begin
      len_eff = pattern_length_r;
    end
  end

  assign shift_bytes = mbss_pkg::LEN_W'(mbss_pkg::MAX_PATTERN) - len_eff;
  assign pattern_all = {pattern_word_r[3], pattern_word_r[2],
                        pattern_word_r[1], pattern_word_r[0]};

  always_comb begin
    cfg_nxt.pattern    = pattern_all << {shift_bytes, 3'b000};
    cfg_nxt.care       = care_mask_r << shift_bytes;
    cfg_nxt.length     = len_eff;
    // match start is index - (len - 1)
    cfg_nxt.offset_adj = address_offset_r + mbss_pkg::ADDR_W'(1)
                         - mbss_pkg::ADDR_W'(len_eff);
  end

  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  assign cfg = cfg_r;

endmodule

FILE: src/mbss_match.sv
`timescale 1ns / 1ps

module mbss_match (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mbss_pkg::scan_cfg_t              cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mbss_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                             in_region_first,
  input  logic [mbss_pkg::ADDR_W-1:0]      in_base_address,
  input  logic                             in_region_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic [mbss_pkg::ADDR_W-1:0]      out_match_address
);

  logic [mbss_pkg::BYTE_W-1:0]      win_r [mbss_pkg::MAX_PATTERN];
  logic [mbss_pkg::ADDR_W-1:0]      run_addr_r;
  logic [mbss_pkg::LEN_W-1:0]       seen_r;
  logic                             reported_r;

  logic                             stg_valid_r;
  logic                             stg_first_r;
  logic                             stg_last_r;
  logic                             stg_seen_ok_r;
  logic [mbss_pkg::ADDR_W-1:0]      stg_addr_r;

  logic                             out_valid_r;
  logic                             out_found_r;
  logic [mbss_pkg::ADDR_W-1:0]      out_addr_r;

  logic                             accept;
  logic                             out_free;
  logic                             stg_adv;
  logic [mbss_pkg::ADDR_W-1:0]      addr_now;
  logic [mbss_pkg::LEN_W-1:0]       seen_base;
  logic [mbss_pkg::LEN_W-1:0]       seen_nxt;
  logic [mbss_pkg::MAX_PATTERN-1:0] slot_ok;
  logic                             win_match;
  logic                             rep_eff;
  logic                             hit;
  logic                             emit;

  assign out_free = ~out_valid_r | out_ready;
  assign stg_adv  = stg_valid_r & out_free;
  assign in_ready = ~stg_valid_r | out_free;
  assign accept   = in_valid & in_ready;

  assign addr_now  = in_region_first ? in_base_address : run_addr_r;
  assign seen_base = in_region_first ? '0 : seen_r;
  assign seen_nxt  = (seen_base < mbss_pkg::LEN_W'(mbss_pkg::MAX_PATTERN)) ?
                     seen_base + mbss_pkg::LEN_W'(1) : seen_base;

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < mbss_pkg::MAX_PATTERN - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[mbss_pkg::MAX_PATTERN-1] <= in_data_byte;
      stg_first_r   <= in_region_first;
      stg_last_r    <= in_region_last;
      stg_seen_ok_r <= seen_nxt >= cfg.length;
      stg_addr_r    <= addr_now + cfg.offset_adj;
    end
  end

  always_comb begin
    for (int k = 0; k < mbss_pkg::MAX_PATTERN; k++) begin
      slot_ok[k] = ~cfg.care[k] || (win_r[k] == cfg.pattern[k*mbss_pkg::BYTE_W +: mbss_pkg::BYTE_W]);
    end
  end

  assign win_match = &slot_ok;
  assign rep_eff   = stg_first_r ? 1'b0 : reported_r;
  assign hit       = ~rep_eff & stg_seen_ok_r & win_match;
  assign emit      = ~rep_eff & (hit | stg_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_addr_r  <= '0;
      seen_r      <= '0;
      reported_r  <= 1'b0;
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        run_addr_r <= addr_now + mbss_pkg::ADDR_W'(1);
        seen_r     <= seen_nxt;
      end
      if (accept) begin
        stg_valid_r <= 1'b1;
      end else if (stg_adv) begin
        stg_valid_r <= 1'b0;
      end
      if (stg_adv) begin
        reported_r <= rep_eff | emit;
      end
      if (stg_adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_adv && emit) begin
      out_found_r <= hit;
      out_addr_r  <= hit ? stg_addr_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

endmodule

FILE: src/masked_byte_signature_scan.sv
`timescale 1ns / 1ps

// Wildcard byte pattern search. Region bytes stream in one per transaction;
// the first byte of a region carries tuser=1 and its base address, the last
// carries tlast. Each byte shifts a 32-byte window, which is compared
// against the configured pattern (up to 32 bytes, care_mask bit clear =
// wildcard). The first match in a region yields out_tuser=1 with address
// base + match start + address_offset (mod 2^32); later matches in that
// region are dropped. A region without a match yields out_tuser=0, address 0,
// on its last byte. Bytes after tlast and before the next first byte give no
// result. One byte is taken every cycle unless out_tready holds back a
// result; each result passes the stage register, then the output
// register, and waits while out_tready holds back an earlier result.
// Program the registers only while no transaction is in flight.

module masked_byte_signature_scan (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [39:0]                          in_tdata,  // data_byte, base_address
  input  logic                                 in_tuser,  // region_first
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [31:0]                          out_tdata, // match_address
  output logic                                 out_tuser, // found
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [mbss_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [mbss_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [mbss_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  mbss_pkg::scan_cfg_t cfg;

  mbss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mbss_match u_match (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_tvalid),
    .in_ready          (in_tready),
    .in_data_byte      (in_tdata[7:0]),
    .in_region_first   (in_tuser),
    .in_base_address   (in_tdata[39:8]),
    .in_region_last    (in_tlast),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_found         (out_tuser),
    .out_match_address (out_tdata)
  );

endmodule
